FILE: rtl/ast_pkg.sv
// ----------------------------------------------------------------------------
// ast_pkg: shared types and constants of the assembly source tokenizer
// Token kinds, error codes, scan modes, character codes and small helpers.
// ----------------------------------------------------------------------------
package ast_pkg;

    // Width of the internal position and length counters
    localparam int CNT_W = 16;

    // Result queue depth (power of two, at least 4) and its pointer width
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [3:0] {
        M_IDLE,
        M_NUMZ,
        M_NUM,
        M_IDENT,
        M_STR,
        M_CH1,
        M_CHESC,
        M_CHESCCL,
        M_CHCL,
        M_ERR
    } mode_t;

    // Token kinds
    localparam logic [3:0] K_COLON = 4'd0;
    localparam logic [3:0] K_DOT   = 4'd1;
    localparam logic [3:0] K_COMMA = 4'd2;
    localparam logic [3:0] K_NL    = 4'd3;
    localparam logic [3:0] K_MINUS = 4'd4;
    localparam logic [3:0] K_LPAR  = 4'd5;
    localparam logic [3:0] K_RPAR  = 4'd6;
    localparam logic [3:0] K_PLUS  = 4'd7;
    localparam logic [3:0] K_INT   = 4'd8;
    localparam logic [3:0] K_FLOAT = 4'd9;
    localparam logic [3:0] K_IDENT = 4'd10;
    localparam logic [3:0] K_CHAR  = 4'd11;
    localparam logic [3:0] K_EOF   = 4'd12;

    // Error codes
    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_FLOAT    = 3'd1;
    localparam logic [2:0] E_STR_OPEN = 3'd2;
    localparam logic [2:0] E_CH_EMPTY = 3'd3;
    localparam logic [2:0] E_CH_OPEN  = 3'd4;
    localparam logic [2:0] E_ESCAPE   = 3'd5;
    localparam logic [2:0] E_STRAY    = 3'd6;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_US    = 8'h5F;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_N  = 8'h6E;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_V  = 8'h76;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    // Running position: byte offset, line and column
    typedef struct packed {
        cnt_t off;
        cnt_t line;
        cnt_t col;
    } ctr_t;

    // One result item
    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] length;
        logic [15:0] line;
        logic [15:0] column;
        logic [15:0] position;
        logic [2:0]  error_code;
        logic        run_last;
    } token_t;

    function automatic cnt_t sat_inc(cnt_t x);
        return (x != '1) ? x + CNT_W'(1) : x;
    endfunction

    // Clamp a counter to the 16-bit output range
    function automatic logic [15:0] out16(cnt_t x);
        if (CNT_W > 16 && x > CNT_W'(17'h0FFFF))
            return 16'hFFFF;
        return 16'(x);
    endfunction

    function automatic ctr_t advance(ctr_t c, logic [7:0] b);
        ctr_t r;
        r.off = sat_inc(c.off);
        if (b == CH_NL)
        begin
            r.line = sat_inc(c.line);
            r.col  = '0;
        end
        else
        begin
            r.line = c.line;
            r.col  = sat_inc(c.col);
        end
        return r;
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b >= CH_0 && b <= CH_9;
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return (b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z);
    endfunction

    function automatic logic is_hexletter(logic [7:0] b);
        return (b >= CH_LO_A && b <= CH_LO_F) || (b >= CH_UP_A && b <= CH_UP_F);
    endfunction

    function automatic logic is_escape(logic [7:0] b);
        return b == CH_SQ || b == CH_LO_A || b == CH_LO_B || b == CH_LO_T ||
               b == CH_LO_N || b == CH_LO_V || b == CH_LO_F || b == CH_LO_R;
    endfunction

    // {hit, kind} for the one-character punctuation tokens
    function automatic logic [4:0] punct_kind(logic [7:0] b);
        case (b)
            CH_COLON: return {1'b1, K_COLON};
            CH_DOT:   return {1'b1, K_DOT};
            CH_COMMA: return {1'b1, K_COMMA};
            CH_NL:    return {1'b1, K_NL};
            CH_MINUS: return {1'b1, K_MINUS};
            CH_LPAR:  return {1'b1, K_LPAR};
            CH_RPAR:  return {1'b1, K_RPAR};
            CH_PLUS:  return {1'b1, K_PLUS};
            default:  return 5'd0;
        endcase
    endfunction

    function automatic token_t mk_tok(logic [3:0] kind, cnt_t len, cnt_t line,
                                      cnt_t col, cnt_t pos, logic [2:0] err);
        token_t t;
        t.kind       = kind;
        t.length     = out16(len);
        t.line       = out16(line);
        t.column     = out16(col);
        t.position   = out16(pos);
        t.error_code = err;
        t.run_last   = 1'b0;
        return t;
    endfunction

endpackage

FILE: rtl/ast_byte_if.sv
// ----------------------------------------------------------------------------
// ast_byte_if: source byte channel
// valid/ready channel carrying one source character per item.
// ----------------------------------------------------------------------------
interface ast_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;

    modport source (output valid, output source_byte, input ready);
    modport sink (input valid, input source_byte, output ready);
endinterface

FILE: rtl/ast_token_if.sv
// ----------------------------------------------------------------------------
// ast_token_if: token result channel
// valid/ready channel carrying one token or error report per item.
// ----------------------------------------------------------------------------
interface ast_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [15:0] token_length;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic [15:0] token_position;
    logic [2:0]  error_code;
    logic        run_last;

    modport source (output valid, output token_kind, output token_length,
                    output token_line, output token_column, output token_position,
                    output error_code, output run_last, input ready);
    modport sink (input valid, input token_kind, input token_length,
                  input token_line, input token_column, input token_position,
                  input error_code, input run_last, output ready);
endinterface

FILE: rtl/assembly_source_tokenizer.sv
// ----------------------------------------------------------------------------
// assembly_source_tokenizer: streaming lexer for assembly source text
// Scans one source byte per cycle while the result queue has room and queues the resulting tokens.
// ----------------------------------------------------------------------------
// One source byte is taken per clock whenever the result queue has room for
// two more items, and the scan state is updated in that same cycle. Each byte
// yields zero, one or two items (two when it closes a number or identifier
// and is itself a punctuation token, a stray character that raises an error,
// or the end byte). Items go into a four-entry queue that drains one item per
// cycle while the sink is ready, so the sustained rate is one byte per cycle as
// long as the sink takes one item per cycle and no byte yields two; ready drops
// only while more than two items wait. After an error report the block
// swallows bytes without output until the end byte (0), which returns it to
// idle with all counters cleared.
module assembly_source_tokenizer (
    input  logic                clk,
    input  logic                rst_n,
    ast_byte_if.sink            src,
    ast_token_if.source         tok
);

    // scan state
    ast_pkg::mode_t mode_reg, mode_next;
    ast_pkg::ctr_t  ctr_reg, ctr_next;
    ast_pkg::cnt_t  so_reg, so_next;      // start offset
    ast_pkg::cnt_t  sl_reg, sl_next;      // start line
    ast_pkg::cnt_t  sc_reg, sc_next;      // start column
    ast_pkg::cnt_t  len_reg, len_next;    // pending length
    logic           dot_reg, dot_next;
    logic           hex_reg, hex_next;
    logic           bsl_reg, bsl_next;

    // result queue
    ast_pkg::token_t             q_reg [ast_pkg::QDEPTH];
    logic [ast_pkg::QPTR_W-1:0]  wp_reg, rp_reg;
    logic [ast_pkg::QPTR_W:0]    cnt_reg;

    logic            acc;
    logic            pop;
    logic            flush_en;
    logic            other_en;
    ast_pkg::token_t flush_tok;
    ast_pkg::token_t other_tok;
    logic [1:0]      push_n;

    assign src.ready = (cnt_reg <= (ast_pkg::QPTR_W+1)'(ast_pkg::QDEPTH - 2));
    assign acc       = src.valid && src.ready;
    assign pop       = tok.valid && tok.ready;

    // ------------------------------------------------------------------
    // Scanner: next state and the up to two items caused by this byte.
    // Slot A is a flushed number/identifier/string/char, slot B is any
    // other item (punctuation, EOF, error); A always comes first.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [7:0]     c;
        ast_pkg::mode_t m;
        ast_pkg::ctr_t  ctr;
        ast_pkg::ctr_t  tmp;
        ast_pkg::cnt_t  so, sl, sc, len;
        logic           dot, hex, bsl;
        logic           skip, idle_en, adv_en, fail_en, clear_en;
        logic [2:0]     fail_code;
        logic [3:0]     flush_kind;
        logic [4:0]     pk;

        c          = src.source_byte;
        m          = mode_reg;
        ctr        = ctr_reg;
        so         = so_reg;
        sl         = sl_reg;
        sc         = sc_reg;
        len        = len_reg;
        dot        = dot_reg;
        hex        = hex_reg;
        bsl        = bsl_reg;
        skip       = 1'b0;
        idle_en    = 1'b0;
        adv_en     = 1'b0;
        fail_en    = 1'b0;
        clear_en   = 1'b0;
        fail_code  = ast_pkg::E_NONE;
        flush_en   = 1'b0;
        flush_kind = ast_pkg::K_INT;
        other_en   = 1'b0;
        other_tok  = '0;
        tmp        = '0;
        pk         = ast_pkg::punct_kind(c);

        // leading zero: 0x / 0X switches to hex
        if (m == ast_pkg::M_NUMZ)
        begin
            m = ast_pkg::M_NUM;
            if (c == ast_pkg::CH_LO_X || c == ast_pkg::CH_UP_X)
            begin
                hex    = 1'b1;
                len    = ast_pkg::sat_inc(len);
                adv_en = 1'b1;
                skip   = 1'b1;
            end
        end

        if (!skip)
        begin
            case (m)
                ast_pkg::M_IDLE:
                    idle_en = 1'b1;
                ast_pkg::M_NUM:
                    if (c == ast_pkg::CH_DOT)
                    begin
                        if (dot || hex)
                        begin
                            fail_en   = 1'b1;
                            fail_code = ast_pkg::E_FLOAT;
                        end
                        else
                        begin
                            dot    = 1'b1;
                            len    = ast_pkg::sat_inc(len);
                            adv_en = 1'b1;
                        end
                    end
                    else if (ast_pkg::is_digit(c) || (hex && ast_pkg::is_hexletter(c)))
                    begin
                        len    = ast_pkg::sat_inc(len);
                        adv_en = 1'b1;
                    end
                    else
                    begin
                        flush_en   = 1'b1;
                        flush_kind = dot ? ast_pkg::K_FLOAT : ast_pkg::K_INT;
                        idle_en    = 1'b1;
                    end
                ast_pkg::M_IDENT:
                    if (ast_pkg::is_alpha(c) || ast_pkg::is_digit(c) ||
                        c == ast_pkg::CH_US || c == ast_pkg::CH_DOT)
                    begin
                        len    = ast_pkg::sat_inc(len);
                        adv_en = 1'b1;
                    end
                    else
                    begin
                        flush_en   = 1'b1;
                        flush_kind = ast_pkg::K_IDENT;
                        idle_en    = 1'b1;
                    end
                ast_pkg::M_STR:
                    if (c == ast_pkg::CH_NUL)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ast_pkg::E_STR_OPEN;
                    end
                    else if (c == ast_pkg::CH_DQ && !bsl)
                    begin
                        flush_en   = 1'b1;
                        flush_kind = ast_pkg::K_IDENT;
                        adv_en     = 1'b1;
                        m          = ast_pkg::M_IDLE;
                    end
                    else
                    begin
                        len    = ast_pkg::sat_inc(len);
                        bsl    = (c == ast_pkg::CH_BSL);
                        adv_en = 1'b1;
                    end
                ast_pkg::M_CH1:
                    if (c == ast_pkg::CH_SQ)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ast_pkg::E_CH_EMPTY;
                    end
                    else if (c == ast_pkg::CH_NUL)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ast_pkg::E_CH_OPEN;
                    end
                    else
                    begin
                        len    = ast_pkg::sat_inc(len);
                        m      = (c == ast_pkg::CH_BSL) ? ast_pkg::M_CHESC
                                                        : ast_pkg::M_CHCL;
                        adv_en = 1'b1;
                    end
                ast_pkg::M_CHESC:
                    if (ast_pkg::is_escape(c))
                    begin
                        len    = ast_pkg::sat_inc(len);
                        m      = ast_pkg::M_CHESCCL;
                        adv_en = 1'b1;
                    end
                    else
                    begin
                        fail_en   = 1'b1;
                        fail_code = ast_pkg::E_ESCAPE;
                    end
                ast_pkg::M_CHESCCL, ast_pkg::M_CHCL:
                    if (c == ast_pkg::CH_SQ)
                    begin
                        len        = ast_pkg::sat_inc(len);
                        flush_en   = 1'b1;
                        flush_kind = ast_pkg::K_CHAR;
                        adv_en     = 1'b1;
                        m          = ast_pkg::M_IDLE;
                    end
                    else
                    begin
                        fail_en   = 1'b1;
                        fail_code = ast_pkg::E_CH_OPEN;
                    end
                default:
                    // discarding after an error
                    if (c == ast_pkg::CH_NUL)
                    begin
                        clear_en = 1'b1;
                        m        = ast_pkg::M_IDLE;
                    end
            endcase
        end

        flush_tok = ast_pkg::mk_tok(flush_kind, len, sl, sc, so, ast_pkg::E_NONE);

        // byte handled between tokens
        if (idle_en)
        begin
            m = ast_pkg::M_IDLE;
            if (c == ast_pkg::CH_NUL)
            begin
                other_en  = 1'b1;
                other_tok = ast_pkg::mk_tok(ast_pkg::K_EOF, ast_pkg::CNT_W'(1), ctr.line,
                                            ctr.col, ctr.off, ast_pkg::E_NONE);
                clear_en  = 1'b1;
            end
            else if (pk[4])
            begin
                other_en  = 1'b1;
                other_tok = ast_pkg::mk_tok(pk[3:0], ast_pkg::CNT_W'(1), ctr.line,
                                            ctr.col, ctr.off, ast_pkg::E_NONE);
                adv_en    = 1'b1;
            end
            else if (c == ast_pkg::CH_SP || c == ast_pkg::CH_TAB ||
                     c == ast_pkg::CH_CR || c == ast_pkg::CH_FF)
            begin
                adv_en = 1'b1;
            end
            else if (ast_pkg::is_digit(c))
            begin
                so     = ctr.off;
                sl     = ctr.line;
                sc     = ctr.col;
                len    = ast_pkg::CNT_W'(1);
                dot    = 1'b0;
                hex    = 1'b0;
                m      = (c == ast_pkg::CH_0) ? ast_pkg::M_NUMZ : ast_pkg::M_NUM;
                adv_en = 1'b1;
            end
            else if (c == ast_pkg::CH_DQ)
            begin
                // string starts after the opening quote
                tmp    = ast_pkg::advance(ctr, c);
                so     = tmp.off;
                sl     = tmp.line;
                sc     = tmp.col;
                len    = '0;
                bsl    = 1'b0;
                m      = ast_pkg::M_STR;
                adv_en = 1'b1;
            end
            else if (c == ast_pkg::CH_SQ)
            begin
                so     = ctr.off;
                sl     = ctr.line;
                sc     = ctr.col;
                len    = ast_pkg::CNT_W'(1);
                m      = ast_pkg::M_CH1;
                adv_en = 1'b1;
            end
            else if (ast_pkg::is_alpha(c) || c == ast_pkg::CH_US)
            begin
                so     = ctr.off;
                sl     = ctr.line;
                sc     = ctr.col;
                len    = ast_pkg::CNT_W'(1);
                m      = ast_pkg::M_IDENT;
                adv_en = 1'b1;
            end
            else
            begin
                fail_en   = 1'b1;
                fail_code = ast_pkg::E_STRAY;
            end
        end

        // error report at the offending byte
        if (fail_en)
        begin
            other_en  = 1'b1;
            other_tok = ast_pkg::mk_tok(ast_pkg::K_COLON, '0, ctr.line, ctr.col,
                                        ctr.off, fail_code);
            if (c == ast_pkg::CH_NUL)
            begin
                clear_en = 1'b1;
                m        = ast_pkg::M_IDLE;
            end
            else
                m = ast_pkg::M_ERR;
        end

        if (adv_en)
            ctr = ast_pkg::advance(ctr, c);

        if (clear_en)
        begin
            ctr = '0;
            so  = '0;
            sl  = '0;
            sc  = '0;
            len = '0;
            dot = 1'b0;
            hex = 1'b0;
            bsl = 1'b0;
        end

        // mark the last item of this byte
        if (other_en)
            other_tok.run_last = 1'b1;
        else
            flush_tok.run_last = 1'b1;

        mode_next = acc ? m   : mode_reg;
        ctr_next  = acc ? ctr : ctr_reg;
        so_next   = acc ? so  : so_reg;
        sl_next   = acc ? sl  : sl_reg;
        sc_next   = acc ? sc  : sc_reg;
        len_next  = acc ? len : len_reg;
        dot_next  = acc ? dot : dot_reg;
        hex_next  = acc ? hex : hex_reg;
        bsl_next  = acc ? bsl : bsl_reg;
    end

    assign push_n = acc ? (2'(flush_en) + 2'(other_en)) : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ast_pkg::M_IDLE;
            ctr_reg  <= '0;
            so_reg   <= '0;
            sl_reg   <= '0;
            sc_reg   <= '0;
            len_reg  <= '0;
            dot_reg  <= 1'b0;
            hex_reg  <= 1'b0;
            bsl_reg  <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            ctr_reg  <= ctr_next;
            so_reg   <= so_next;
            sl_reg   <= sl_next;
            sc_reg   <= sc_next;
            len_reg  <= len_next;
            dot_reg  <= dot_next;
            hex_reg  <= hex_next;
            bsl_reg  <= bsl_next;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: up to two writes, one read per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            if (flush_en)
            begin
                q_reg[wp_reg] <= flush_tok;
                if (other_en)
                    q_reg[wp_reg + ast_pkg::QPTR_W'(1)] <= other_tok;
            end
            else if (other_en)
                q_reg[wp_reg] <= other_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + ast_pkg::QPTR_W'(push_n);
            rp_reg  <= rp_reg + ast_pkg::QPTR_W'(pop);
            cnt_reg <= cnt_reg + (ast_pkg::QPTR_W+1)'(push_n)
                               - (ast_pkg::QPTR_W+1)'(pop);
        end
    end

    assign tok.valid          = (cnt_reg != '0);
    assign tok.token_kind     = q_reg[rp_reg].kind;
    assign tok.token_length   = q_reg[rp_reg].length;
    assign tok.token_line     = q_reg[rp_reg].line;
    assign tok.token_column   = q_reg[rp_reg].column;
    assign tok.token_position = q_reg[rp_reg].position;
    assign tok.error_code     = q_reg[rp_reg].error_code;
    assign tok.run_last       = q_reg[rp_reg].run_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (ast_pkg::QPTR_W+1)'(ast_pkg::QDEPTH))
        else $error("result queue overflow");

    a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && mode_reg == ast_pkg::M_ERR) |-> (push_n == 2'd0))
        else $error("item produced while discarding after error");

    a_two_only_on_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd2) |-> (mode_reg == ast_pkg::M_NUM || mode_reg == ast_pkg::M_NUMZ ||
                              mode_reg == ast_pkg::M_IDENT))
        else $error("two items from a byte that closes no token");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && src.source_byte == ast_pkg::CH_NUL) |=>
            (mode_reg == ast_pkg::M_IDLE && ctr_reg == '0))
        else $error("end byte did not return scanner to idle");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for assembly_source_tokenizer
// Drives source bytes over valid/ready with random idling on both sides.
// Every accepted byte runs through a local lexer model; every token item
// leaving the block is checked field by field against it or a directed row.
// ----------------------------------------------------------------------------
module tb_top;

    import ast_pkg::*;

    // Cycles with no item accepted on either port before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // Source bytes to send over the whole run, directed part included
    localparam int ITEM_TARGET = 740;
    // Error items always carry kind 0
    localparam logic [3:0] ERR_KIND = K_COLON;

    logic clk = 1'b0;
    logic rst_n;

    ast_byte_if  src_bus ();
    ast_token_if tok_bus ();

    assembly_source_tokenizer DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src_bus),
        .tok   (tok_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Lexer model state
    // ------------------------------------------------------------------
    mode_t       scan;
    logic [15:0] off, line, col;          // running position
    logic [15:0] s_off, s_line, s_col;    // start of the pending token
    logic [15:0] tok_len;
    bit          has_dot, hex_num, after_bsl;

    token_t lex_out [$];      // items produced by the byte just taken
    token_t tokens_due [$];   // items still owed by the block

    // Directed table
    typedef struct {
        logic [7:0] ch;
        bit         typed;     // want holds a hand-written expectation
        token_t     want;
    } step_row_t;

    step_row_t script [$];
    logic [7:0] text [$];     // one random source, end byte included

    // Handshake side info, driven together with the byte
    bit     cur_typed = 1'b0;
    token_t cur_want  = '0;
    token_t blank     = '0;

    bit no_idle    = 1'b0;    // stretch with both sides at full rate
    int sink_hold  = 0;
    int mismatches = 0;
    int sent       = 0;
    int quiet_cycles = 0;

    logic [7:0] punct_set [8] = '{CH_COLON, CH_DOT, CH_COMMA, CH_NL,
                                  CH_MINUS, CH_LPAR, CH_RPAR, CH_PLUS};
    logic [7:0] space_set [4] = '{CH_SP, CH_TAB, CH_CR, CH_FF};
    logic [7:0] esc_set [8]   = '{CH_SQ, CH_LO_A, CH_LO_B, CH_LO_T,
                                  CH_LO_N, CH_LO_V, CH_LO_F, CH_LO_R};

    // ------------------------------------------------------------------
    // Model helpers
    // ------------------------------------------------------------------
    function automatic logic [15:0] bump(input logic [15:0] x);
        return (x == 16'hFFFF) ? x : x + 16'd1;
    endfunction

    function automatic bit is_dec(input logic [7:0] b);
        return b >= CH_0 && b <= CH_9;
    endfunction

    function automatic bit is_letter(input logic [7:0] b);
        return (b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z);
    endfunction

    function automatic bit is_hexalpha(input logic [7:0] b);
        return (b >= CH_LO_A && b <= CH_LO_F) || (b >= CH_UP_A && b <= CH_UP_F);
    endfunction

    function automatic bit is_esc_letter(input logic [7:0] b);
        bit hit;
        hit = 1'b0;
        foreach (esc_set[i])
            if (esc_set[i] == b)
                hit = 1'b1;
        return hit;
    endfunction

    function automatic bit punct_of(input logic [7:0] b, output logic [3:0] k);
        punct_of = 1'b1;
        k = K_COLON;
        case (b)
            CH_COLON: k = K_COLON;
            CH_DOT:   k = K_DOT;
            CH_COMMA: k = K_COMMA;
            CH_NL:    k = K_NL;
            CH_MINUS: k = K_MINUS;
            CH_LPAR:  k = K_LPAR;
            CH_RPAR:  k = K_RPAR;
            CH_PLUS:  k = K_PLUS;
            default:  punct_of = 1'b0;
        endcase
    endfunction

    function automatic token_t make_tok(input logic [3:0] kind, input logic [15:0] len,
                                        input logic [15:0] ln, input logic [15:0] cl,
                                        input logic [15:0] pos, input logic [2:0] err);
        token_t t;
        t.kind       = kind;
        t.length     = len;
        t.line       = ln;
        t.column     = cl;
        t.position   = pos;
        t.error_code = err;
        t.run_last   = 1'b0;
        return t;
    endfunction

    task automatic zero_all();
        off = '0; line = '0; col = '0;
        s_off = '0; s_line = '0; s_col = '0; tok_len = '0;
        has_dot = 1'b0; hex_num = 1'b0; after_bsl = 1'b0;
    endtask

    // Newline moves to the next line, anything else one column on
    task automatic step_pos(input logic [7:0] b);
        off = bump(off);
        if (b == CH_NL)
        begin
            line = bump(line);
            col  = '0;
        end
        else
        begin
            col = bump(col);
        end
    endtask

    task automatic mark_here();
        s_off  = off;
        s_line = line;
        s_col  = col;
    endtask

    task automatic put(input logic [3:0] kind, input logic [15:0] len,
                       input logic [15:0] ln, input logic [15:0] cl,
                       input logic [15:0] pos, input logic [2:0] err);
        lex_out.push_back(make_tok(kind, len, ln, cl, pos, err));
    endtask

    task automatic put_pending(input logic [3:0] kind);
        put(kind, tok_len, s_line, s_col, s_off, E_NONE);
    endtask

    // Error report at the offending byte; an end byte clears at once
    task automatic raise(input logic [2:0] code, input logic [7:0] b);
        put(ERR_KIND, '0, line, col, off, code);
        if (b == CH_NUL)
        begin
            zero_all();
            scan = M_IDLE;
        end
        else
        begin
            scan = M_ERR;
        end
    endtask

    task automatic lex_idle(input logic [7:0] b);
        logic [3:0] pk;
        scan = M_IDLE;
        if (b == CH_NUL)
        begin
            put(K_EOF, 16'd1, line, col, off, E_NONE);
            zero_all();
        end
        else if (punct_of(b, pk))
        begin
            put(pk, 16'd1, line, col, off, E_NONE);
            step_pos(b);
        end
        else if (b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_FF)
        begin
            step_pos(b);
        end
        else if (is_dec(b))
        begin
            mark_here();
            tok_len = 16'd1;
            has_dot = 1'b0;
            hex_num = 1'b0;
            scan = (b == CH_0) ? M_NUMZ : M_NUM;
            step_pos(b);
        end
        else if (b == CH_DQ)
        begin
            // string starts after the opening quote
            step_pos(b);
            mark_here();
            tok_len = '0;
            after_bsl = 1'b0;
            scan = M_STR;
        end
        else if (b == CH_SQ)
        begin
            mark_here();
            tok_len = 16'd1;
            scan = M_CH1;
            step_pos(b);
        end
        else if (is_letter(b) || b == CH_US)
        begin
            mark_here();
            tok_len = 16'd1;
            scan = M_IDENT;
            step_pos(b);
        end
        else
        begin
            raise(E_STRAY, b);
        end
    endtask

    // One source byte through the model; results land in lex_out
    task automatic lex_byte(input logic [7:0] b);
        lex_out.delete();
        if (scan == M_NUMZ)
        begin
            if (b == CH_LO_X || b == CH_UP_X)
            begin
                hex_num = 1'b1;
                tok_len = bump(tok_len);
                step_pos(b);
                scan = M_NUM;
                return;
            end
            scan = M_NUM;
        end

        case (scan)
            M_IDLE:
                lex_idle(b);
            M_NUM:
                if (b == CH_DOT)
                begin
                    if (has_dot || hex_num)
                        raise(E_FLOAT, b);
                    else
                    begin
                        has_dot = 1'b1;
                        tok_len = bump(tok_len);
                        step_pos(b);
                    end
                end
                else if (is_dec(b) || (hex_num && is_hexalpha(b)))
                begin
                    tok_len = bump(tok_len);
                    step_pos(b);
                end
                else
                begin
                    put_pending(has_dot ? K_FLOAT : K_INT);
                    lex_idle(b);
                end
            M_IDENT:
                if (is_letter(b) || is_dec(b) || b == CH_US || b == CH_DOT)
                begin
                    tok_len = bump(tok_len);
                    step_pos(b);
                end
                else
                begin
                    put_pending(K_IDENT);
                    lex_idle(b);
                end
            M_STR:
                if (b == CH_NUL)
                    raise(E_STR_OPEN, b);
                else if (b == CH_DQ && !after_bsl)
                begin
                    put_pending(K_IDENT);
                    step_pos(b);
                    scan = M_IDLE;
                end
                else
                begin
                    tok_len = bump(tok_len);
                    after_bsl = (b == CH_BSL);
                    step_pos(b);
                end
            M_CH1:
                if (b == CH_SQ)
                    raise(E_CH_EMPTY, b);
                else if (b == CH_NUL)
                    raise(E_CH_OPEN, b);
                else
                begin
                    tok_len = bump(tok_len);
                    scan = (b == CH_BSL) ? M_CHESC : M_CHCL;
                    step_pos(b);
                end
            M_CHESC:
                if (is_esc_letter(b))
                begin
                    tok_len = bump(tok_len);
                    scan = M_CHESCCL;
                    step_pos(b);
                end
                else
                begin
                    raise(E_ESCAPE, b);
                end
            M_CHESCCL, M_CHCL:
                if (b == CH_SQ)
                begin
                    tok_len = bump(tok_len);
                    put_pending(K_CHAR);
                    step_pos(b);
                    scan = M_IDLE;
                end
                else
                begin
                    raise(E_CH_OPEN, b);
                end
            default:
                // discard until the end byte
                if (b == CH_NUL)
                begin
                    zero_all();
                    scan = M_IDLE;
                end
        endcase

        if (lex_out.size() > 0)
            lex_out[lex_out.size() - 1].run_last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic row(input logic [7:0] ch);
        script.push_back('{ch: ch, typed: 1'b0, want: '0});
    endtask

    // Row with a hand-written single result (run_last set)
    task automatic row_chk(input logic [7:0] ch, input logic [3:0] kind,
                           input logic [15:0] len, input logic [15:0] ln,
                           input logic [15:0] cl, input logic [15:0] pos,
                           input logic [2:0] err);
        token_t t;
        t = make_tok(kind, len, ln, cl, pos, err);
        t.run_last = 1'b1;
        script.push_back('{ch: ch, typed: 1'b1, want: t});
    endtask

    function automatic logic [7:0] rnd_letter();
        return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rnd_digit();
        return CH_0 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rnd_hex();
        case ($urandom_range(0, 2))
            0:       return rnd_digit();
            1:       return CH_LO_A + 8'($urandom_range(0, 5));
            default: return CH_UP_A + 8'($urandom_range(0, 5));
        endcase
    endfunction

    // Appends one lexeme, mostly well formed; end_now asks to close the
    // source right here (literal left open at the end byte)
    task automatic add_fragment(output bit end_now);
        int         pick;
        logic [7:0] c;
        end_now = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 18)
            text.push_back(punct_set[$urandom_range(0, 7)]);
        else if (pick < 30)
            text.push_back(space_set[$urandom_range(0, 3)]);
        else if (pick < 45)
        begin
            repeat ($urandom_range(1, 4)) text.push_back(rnd_digit());
            if ($urandom_range(0, 2) == 0)
            begin
                text.push_back(CH_DOT);
                repeat ($urandom_range(0, 3)) text.push_back(rnd_digit());
            end
        end
        else if (pick < 55)
        begin
            text.push_back(CH_0);
            text.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
            repeat ($urandom_range(0, 4)) text.push_back(rnd_hex());
        end
        else if (pick < 70)
        begin
            text.push_back(($urandom_range(0, 5) == 0) ? CH_US : rnd_letter());
            repeat ($urandom_range(0, 6))
            begin
                case ($urandom_range(0, 5))
                    0, 1, 2: text.push_back(rnd_letter());
                    3:       text.push_back(rnd_digit());
                    4:       text.push_back(CH_US);
                    default: text.push_back(CH_DOT);
                endcase
            end
        end
        else if (pick < 80)
        begin
            text.push_back(CH_DQ);
            repeat ($urandom_range(0, 6))
            begin
                c = ($urandom_range(0, 9) == 0) ? CH_NL : 8'($urandom_range(32, 126));
                if (c == CH_DQ)
                    text.push_back(CH_BSL);
                text.push_back(c);
            end
            text.push_back(CH_DQ);
        end
        else if (pick < 90)
        begin
            text.push_back(CH_SQ);
            if ($urandom_range(0, 1))
            begin
                text.push_back(CH_BSL);
                text.push_back(esc_set[$urandom_range(0, 7)]);
            end
            else
            begin
                c = 8'($urandom_range(1, 255));
                text.push_back((c == CH_SQ || c == CH_BSL) ? CH_LO_Z : c);
            end
            text.push_back(CH_SQ);
        end
        else if (pick < 96)
        begin
            // broken lexemes
            case ($urandom_range(0, 5))
                0:
                begin
                    text.push_back(CH_SQ);
                    text.push_back(CH_SQ);
                end
                1:
                begin
                    text.push_back(CH_SQ);
                    text.push_back(CH_BSL);
                    text.push_back(8'($urandom_range(1, 255)));
                end
                2:
                begin
                    text.push_back(CH_SQ);
                    text.push_back(rnd_letter());
                    text.push_back(rnd_letter());
                end
                3:
                begin
                    text.push_back(rnd_digit());
                    text.push_back(CH_DOT);
                    text.push_back(rnd_digit());
                    text.push_back(CH_DOT);
                end
                4:
                begin
                    text.push_back(CH_0);
                    text.push_back(CH_LO_X);
                    text.push_back(rnd_hex());
                    text.push_back(CH_DOT);
                end
                default:
                begin
                    end_now = 1'b1;
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            text.push_back(CH_DQ);
                            text.push_back(rnd_letter());
                        end
                        1: text.push_back(CH_SQ);
                        2:
                        begin
                            text.push_back(CH_SQ);
                            text.push_back(CH_BSL);
                        end
                        default:
                        begin
                            text.push_back(CH_SQ);
                            text.push_back(rnd_letter());
                        end
                    endcase
                end
            endcase
        end
        else
            text.push_back(8'($urandom_range(1, 255)));   // noise, high bytes too
    endtask

    task automatic compose_source();
        bit stop;
        int count;
        text.delete();
        stop = 1'b0;
        count = $urandom_range(1, 12);
        while (count > 0 && !stop)
        begin
            add_fragment(stop);
            count--;
        end
        text.push_back(CH_NUL);
    endtask

    // Sender side: random gap, then hold the byte until it is taken.
    // Returns just after the accepting rising edge.
    task automatic send_byte(input logic [7:0] b, input bit typed, input token_t want);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            src_bus.valid = 1'b0;
        end
        @(negedge clk);
        src_bus.valid       = 1'b1;
        src_bus.source_byte = b;
        cur_typed           = typed;
        cur_want            = want;
        @(posedge clk);
        while (!src_bus.ready)
            @(posedge clk);
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        src_bus.valid = 1'b0;
        while (tokens_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic flag_error(input string why, input token_t want, input token_t got);
        if (mismatches < 10)
            $display("%0t %s: want k%0d len%0d ln%0d col%0d pos%0d err%0d last%0d,",
                     $time, why,
                     want.kind, want.length, want.line, want.column, want.position,
                     want.error_code, want.run_last,
                     " got k%0d len%0d ln%0d col%0d pos%0d err%0d last%0d",
                     got.kind, got.length, got.line, got.column, got.position,
                     got.error_code, got.run_last);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Token sink: ready dropped at random, changed on the falling edge
    // ------------------------------------------------------------------
    initial
    begin
        tok_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                tok_bus.ready = 1'b0;
                sink_hold--;
            end
            else
            begin
                sink_hold = pick_gap();
                tok_bus.ready = (sink_hold == 0);
                if (sink_hold != 0)
                    sink_hold--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: model update on byte accept, check on item accept, and the
    // stall watchdog. Both ports sampled on the rising edge only.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        token_t got;
        token_t want;
        bit     moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (src_bus.valid && src_bus.ready)
            begin
                moved = 1'b1;
                sent++;
                lex_byte(src_bus.source_byte);
                if (cur_typed)
                    tokens_due.push_back(cur_want);
                else
                    foreach (lex_out[i])
                        tokens_due.push_back(lex_out[i]);
            end
            if (tok_bus.valid && tok_bus.ready)
            begin
                moved = 1'b1;
                got = make_tok(tok_bus.token_kind, tok_bus.token_length, tok_bus.token_line,
                               tok_bus.token_column, tok_bus.token_position,
                               tok_bus.error_code);
                got.run_last = tok_bus.run_last;
                if (tokens_due.size() == 0)
                    flag_error("token with nothing expected", '0, got);
                else
                begin
                    want = tokens_due.pop_front();
                    if (got.kind !== want.kind || got.length !== want.length ||
                        got.line !== want.line || got.column !== want.column ||
                        got.position !== want.position ||
                        got.error_code !== want.error_code ||
                        got.run_last !== want.run_last)
                        flag_error("token mismatch", want, got);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("assembly_source_tokenizer regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        src_bus.valid = 1'b0;
        src_bus.source_byte = CH_NUL;
        scan = M_IDLE;
        zero_all();

        // Directed table. Hand-written results are the ones that follow
        // straight from reset or cleared counters; the rest use the model.
        row_chk(CH_COLON, K_COLON, 16'd1, 16'd0, 16'd0, 16'd0, E_NONE);
        row_chk(CH_NL, K_NL, 16'd1, 16'd0, 16'd1, 16'd1, E_NONE);
        // lone 0x closed by a paren: int of length 2 plus lpar
        row(CH_0);
        row(CH_LO_X);
        row(CH_LPAR);
        // string holding a backslash-escaped quote
        row(CH_DQ);
        row(CH_BSL);
        row(CH_DQ);
        row(CH_DQ);
        // end byte: EOF, counters cleared
        row(CH_NUL);
        // stray high byte, then discard until the end byte
        row_chk(8'hFF, ERR_KIND, 16'd0, 16'd0, 16'd0, 16'd0, E_STRAY);
        row(CH_DQ);
        row(CH_NUL);
        // empty char literal
        row(CH_SQ);
        row_chk(CH_SQ, ERR_KIND, 16'd0, 16'd0, 16'd1, 16'd1, E_CH_EMPTY);
        row(CH_NUL);
        // second dot in a number
        row(CH_9);
        row(CH_DOT);
        row_chk(CH_DOT, ERR_KIND, 16'd0, 16'd0, 16'd2, 16'd2, E_FLOAT);
        row(CH_NUL);
        // string open at the end byte: error, no EOF
        row(CH_DQ);
        row_chk(CH_NUL, ERR_KIND, 16'd0, 16'd0, 16'd1, 16'd1, E_STR_OPEN);
        // char literal not closed
        row(CH_SQ);
        row(CH_LO_Z);
        row_chk(CH_LO_R, ERR_KIND, 16'd0, 16'd0, 16'd2, 16'd2, E_CH_OPEN);
        row(CH_NUL);
        // escape cut by the end byte
        row(CH_SQ);
        row(CH_BSL);
        row_chk(CH_NUL, ERR_KIND, 16'd0, 16'd0, 16'd2, 16'd2, E_ESCAPE);
        // empty source
        row_chk(CH_NUL, K_EOF, 16'd1, 16'd0, 16'd0, 16'd0, E_NONE);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (script[i])
            send_byte(script[i].ch, script[i].typed, script[i].want);

        // sender waits for every owed item at least once
        hold_until_drained();

        // Random sources; some at full rate, some after a full drain
        while (sent < ITEM_TARGET)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 19) == 0)
                hold_until_drained();
            compose_source();
            foreach (text[i])
                send_byte(text[i], 1'b0, blank);
        end
        no_idle = 1'b0;

        @(negedge clk);
        src_bus.valid = 1'b0;
        while (tokens_due.size() != 0)
            @(posedge clk);
        // catch any stray item the block still emits
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("assembly_source_tokenizer regression: pass");
        else
            $display("assembly_source_tokenizer regression: fail");
        $finish;
    end

endmodule
